FILE: hdl/thermometer_scratchpad_to_temperature_defines.svh
// assertion helpers shared by the thermometer scratchpad converter
`ifndef THERMOMETER_SCRATCHPAD_TO_TEMPERATURE_DEFINES_SVH
`define THERMOMETER_SCRATCHPAD_TO_TEMPERATURE_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define TSCT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("tsct check failed");

// next-cycle implication, quiet while reset is asserted
`define TSCT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("tsct check failed");

`endif

FILE: hdl/tsct_pkg.sv
package tsct_pkg;

	localparam int NUM_W   = 17;
	localparam int REM_W   = 8;
	localparam int NCELLS  = NUM_W;
	localparam int BASE_W  = 26;
	localparam int MILLI_W = 25;
	localparam int SIX_W   = 20;

	localparam int MILLI_PER_DEG     = 1000;
	localparam int COARSE_OFF_MILLI  = 250;
	localparam int COARSE_OFF_SIX    = 4;
	localparam logic [1:0] RES_FULL  = 2'd3;

	typedef enum logic [1:0] {
		MODE_FINE,
		MODE_PLAIN,
		MODE_EXT
	} mode_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [NUM_W-1:0] num;
	} div_lane_t;

	typedef struct packed {
		mode_t                    mode;
		logic [1:0]               res;
		logic                     neg;
		logic signed [BASE_W-1:0] milli_base;
		logic signed [SIX_W-1:0]  six_base;
	} side_t;

	typedef struct packed {
		logic             valid;
		logic [REM_W-1:0] divisor;
		div_lane_t        lane_m;
		div_lane_t        lane_s;
		side_t            side;
	} cell_t;

endpackage

FILE: hdl/thermometer_scratchpad_to_temperature.sv
// scratchpad to temperature converter for a 1-wire thermometer
// input: raise start with the scratchpad fields for one cycle; the item is
//   taken at the rising edge where start is high and busy is low
// busy is high only while arst_n is asserted and for the first edge after;
//   from then on an item can be taken at every edge
// output: done is high for exactly one cycle with temp_milli and
//   temp_sixteenths; the receiver cannot stall, results are never held
// pipeline: one register for the input scaling, 17 divider cells (one quotient
//   bit each, sized by the 17-bit milli numerator) and the output register
// throughput: one item per cycle, the divider cells form a pipeline
// config: cfg_wr_en writes cfg_wr_data into ext_res_enable (reset 1); write
//   it only while no item is in flight
// reset: asynchronous, active low; clears all valid flags, no item survives
`include "thermometer_scratchpad_to_temperature_defines.svh"

module thermometer_scratchpad_to_temperature (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [7:0]                          temp_lsb,
	input  logic [7:0]                          temp_msb,
	input  logic [7:0]                          config_byte,
	input  logic [7:0]                          count_remain,
	input  logic [7:0]                          count_per_c,
	input  logic                                coarse_sensor,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_wr_data,
	output logic                                done,
	output logic signed [tsct_pkg::MILLI_W-1:0] temp_milli,
	output logic signed [tsct_pkg::SIX_W-1:0]   temp_sixteenths
);
	import tsct_pkg::*;

	localparam int LAT = NCELLS + 2;

	logic  busy_q;
	logic  ext_res_enable_q;
	logic  in_acc;
	cell_t chain [NCELLS+1];

	assign in_acc = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q           <= 1'b1;
			ext_res_enable_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			if (cfg_wr_en) begin
				ext_res_enable_q <= cfg_wr_data;
			end
		end
	end

	tsct_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_acc),
		.ext_en        (ext_res_enable_q),
		.temp_lsb      (temp_lsb),
		.temp_msb      (temp_msb),
		.config_byte   (config_byte),
		.count_remain  (count_remain),
		.count_per_c   (count_per_c),
		.coarse_sensor (coarse_sensor),
		.q             (chain[0])
	);

	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		tsct_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	tsct_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.d               (chain[NCELLS]),
		.done            (done),
		.temp_milli      (temp_milli),
		.temp_sixteenths (temp_sixteenths)
	);

	// every accepted item comes out exactly once, a fixed time later
	`TSCT_ASSERT_IMP(a_latency, clk, arst_n, 1'b1, done == ($past(in_acc, LAT) === 1'b1))
	// extended items never reach the divider with a zero divisor
	`TSCT_ASSERT_IMP(a_div_nz, clk, arst_n, chain[NCELLS].valid && chain[NCELLS].side.mode == MODE_EXT, chain[NCELLS].divisor != '0)
	// a finished division leaves a remainder below the divisor
	`TSCT_ASSERT_IMP(a_rem_ok, clk, arst_n, chain[NCELLS].valid && chain[NCELLS].side.mode == MODE_EXT, chain[NCELLS].lane_m.rem < chain[NCELLS].divisor && chain[NCELLS].lane_s.rem < chain[NCELLS].divisor)
	// items outside the extended path carry an empty quotient
	`TSCT_ASSERT_IMP(a_q_zero, clk, arst_n, chain[NCELLS].valid && chain[NCELLS].side.mode != MODE_EXT, chain[NCELLS].lane_m.num == '0 && chain[NCELLS].lane_s.num == '0)

endmodule

FILE: hdl/tsct_front.sv
module tsct_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic           ext_en,
	input  logic [7:0]     temp_lsb,
	input  logic [7:0]     temp_msb,
	input  logic [7:0]     config_byte,
	input  logic [7:0]     count_remain,
	input  logic [7:0]     count_per_c,
	input  logic           coarse_sensor,
	output tsct_pkg::cell_t q
);
	import tsct_pkg::*;

	logic signed [15:0]   raw;
	logic [1:0]           res;
	logic [1:0]           shf;
	logic signed [15:0]   t;
	logic signed [15:0]   half;
	logic                 ext;
	logic [7:0]           diff;
	logic                 neg;
	logic [8:0]           mag;
	mode_t                mode;
	logic signed [15:0]   mop;
	logic signed [10:0]   mk;
	logic signed [26:0]   prod;
	logic [15:0]          mask;
	logic [15:0]          fine_six;
	logic signed [SIX_W-1:0] six_base;
	cell_t                d;

	always_comb begin
		raw  = signed'({temp_msb, temp_lsb});
		res  = config_byte[6:5];
		shf  = RES_FULL - res;
		t    = raw >>> shf;
		half = raw >>> 1;
		ext  = coarse_sensor && ext_en && (count_per_c != '0);
		diff = count_per_c - count_remain;
		neg  = diff[7];
		mag  = neg ? (9'd256 - {1'b0, diff}) : {1'b0, diff};

		priority if (!coarse_sensor) begin
			mode = MODE_FINE;
		end else if (ext) begin
			mode = MODE_EXT;
		end else begin
			mode = MODE_PLAIN;
		end

		mask     = (16'h1 << shf) - 16'h1;
		fine_six = raw & ~mask;

		unique case (mode)
			MODE_FINE: begin
				mop      = t;
				mk       = 11'(MILLI_PER_DEG);
				six_base = SIX_W'(signed'(fine_six));
			end
			MODE_EXT: begin
				mop      = half;
				mk       = 11'(MILLI_PER_DEG);
				six_base = SIX_W'(half) <<< 4;
			end
			MODE_PLAIN: begin
				mop      = raw;
				mk       = 11'(MILLI_PER_DEG / 2);
				six_base = SIX_W'(raw) <<< 3;
			end
			default: begin
				mop      = raw;
				mk       = 11'(MILLI_PER_DEG / 2);
				six_base = SIX_W'(raw) <<< 3;
			end
		endcase
		prod = 27'(mop) * 27'(mk);

		d.valid           = accept;
		// outside the extended path the numerators are zero, so the quotient stays empty; the divisor is one
		d.divisor         = ext ? count_per_c : 8'd1;
		d.lane_m.rem      = '0;
		d.lane_s.rem      = '0;
		d.lane_m.num      = ext ? (NUM_W'(mag) * NUM_W'(MILLI_PER_DEG)) : '0;
		d.lane_s.num      = ext ? NUM_W'({mag, 4'b0}) : '0;
		d.side.mode       = mode;
		d.side.res        = res;
		d.side.neg        = neg;
		d.side.milli_base = signed'(prod[BASE_W-1:0]);
		d.side.six_base   = six_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q.valid <= 1'b0;
		end else begin
			q <= d;
		end
	end

endmodule

FILE: hdl/tsct_cell.sv
module tsct_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  tsct_pkg::cell_t d,
	output tsct_pkg::cell_t q
);
	import tsct_pkg::*;

	cell_t nxt;

	// one restoring step: pull the next numerator bit into the remainder
	function automatic div_lane_t div_step(input div_lane_t l, input logic [REM_W-1:0] dv);
		logic [REM_W:0] rem_sh;
		logic           ge;
		div_lane_t      r;
		rem_sh = {l.rem, l.num[NUM_W-1]};
		ge     = rem_sh >= {1'b0, dv};
		r.rem  = ge ? REM_W'(rem_sh - {1'b0, dv}) : rem_sh[REM_W-1:0];
		r.num  = {l.num[NUM_W-2:0], ge};
		return r;
	endfunction

	always_comb begin
		nxt        = d;
		nxt.lane_m = div_step(d.lane_m, d.divisor);
		nxt.lane_s = div_step(d.lane_s, d.divisor);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q.valid <= 1'b0;
		end else begin
			q <= nxt;
		end
	end

endmodule

FILE: hdl/tsct_back.sv
module tsct_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tsct_pkg::cell_t              d,
	output logic                         done,
	output logic signed [tsct_pkg::MILLI_W-1:0] temp_milli,
	output logic signed [tsct_pkg::SIX_W-1:0]   temp_sixteenths
);
	import tsct_pkg::*;

	logic signed [BASE_W:0]   qm_s;
	logic signed [BASE_W:0]   term_m;
	logic signed [SIX_W:0]    qs_s;
	logic signed [SIX_W:0]    term_s;
	logic [2:0]               shamt;
	logic [BASE_W-1:0]        bias;
	logic signed [BASE_W-1:0] fine_sum;
	logic signed [BASE_W:0]   milli_n;
	logic signed [SIX_W:0]    six_n;
	logic                     done_q;
	logic signed [MILLI_W-1:0] milli_q;
	logic signed [SIX_W-1:0]   six_q;

	always_comb begin
		qm_s   = signed'((BASE_W + 1)'(d.lane_m.num));
		term_m = d.side.neg ? -qm_s : qm_s;
		qs_s   = signed'((SIX_W + 1)'(d.lane_s.num));
		term_s = d.side.neg ? -qs_s : qs_s;

		// truncate toward zero: bias negative values before the shift
		shamt    = 3'(d.side.res) + 3'd1;
		bias     = d.side.milli_base[BASE_W-1] ?
			((BASE_W'(1) << shamt) - BASE_W'(1)) : '0;
		fine_sum = d.side.milli_base + signed'(bias);

		unique case (d.side.mode)
			MODE_FINE: begin
				milli_n = (BASE_W + 1)'(fine_sum >>> shamt);
				six_n   = (SIX_W + 1)'(d.side.six_base);
			end
			MODE_EXT: begin
				milli_n = (BASE_W + 1)'(d.side.milli_base) + term_m
					- (BASE_W + 1)'(COARSE_OFF_MILLI);
				six_n   = (SIX_W + 1)'(d.side.six_base) + term_s
					- (SIX_W + 1)'(COARSE_OFF_SIX);
			end
			MODE_PLAIN: begin
				milli_n = (BASE_W + 1)'(d.side.milli_base);
				six_n   = (SIX_W + 1)'(d.side.six_base);
			end
			default: begin
				milli_n = (BASE_W + 1)'(d.side.milli_base);
				six_n   = (SIX_W + 1)'(d.side.six_base);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		milli_q <= signed'(milli_n[MILLI_W-1:0]);
		six_q   <= signed'(six_n[SIX_W-1:0]);
	end

	assign done            = done_q;
	assign temp_milli      = milli_q;
	assign temp_sixteenths = six_q;

endmodule
